// File: rtl/sstf_pkg.sv
// Package for the SSTF disk request scheduler.
// Field widths, register map codes and default sizes; no dependencies.
package sstf_pkg;

  localparam int TrackW = 8;
  localparam int DepthW = 5;
  localparam int DataW  = 32;
  localparam int AddrW  = 3;

  localparam int QueueDepthDef = 16;
  localparam int TrackCountDef = 200;

  localparam logic [DepthW-1:0] DepthReset = 5'd10;

  // Register index, taken from paddr[2]
  localparam logic RegStartTrack  = 1'b0;
  localparam logic RegActiveDepth = 1'b1;

endpackage

// File: rtl/sstf_disk_request_scheduler_unit.sv
// Top level of the SSTF disk request scheduler: queue, nearest-track sequencer, APB registers.
// Depends on sstf_pkg.
//
// Each request on the slave stream is accepted only when the scheduler is idle. One
// comparator walks the queue slot by slot (one slot per cycle, read from a registered
// memory) for every accepted request. When the queue holds at least active_depth tracks
// (capped at QUEUE_DEPTH), the request first serves the pending track nearest the head and
// emits it with its seek distance. A request with tlast set then drains the queue, one
// extra scan per pending track; tlast on the master side marks the final result of that
// drain. Writing start_track moves the head at once. The track and distance payloads are
// 8 bits wide.
module sstf_disk_request_scheduler_unit import sstf_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDef,
  parameter int TRACK_COUNT = TrackCountDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,

  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] track
  input  logic             s_axis_tlast,   // end_of_stream

  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [7:0] served_track, [15:8] seek_distance
  output logic             m_axis_tlast,   // last

  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OccW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IdxW-1:0]   LastIdx  = IdxW'(QUEUE_DEPTH - 1);
  localparam logic [OccW-1:0]   OccDepth = OccW'(QUEUE_DEPTH);
  localparam logic [TrackW-1:0] TrackMax =
    (TRACK_COUNT > 256) ? 8'hFF : TrackW'(TRACK_COUNT - 1);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SCAN     = 3'd1;
  localparam logic [2:0] S_SCAN_END = 3'd2;
  localparam logic [2:0] S_SERVE    = 3'd3;
  localparam logic [2:0] S_INSERT   = 3'd4;

  logic [2:0]             state_q;
  logic [IdxW-1:0]        scan_idx_q;
  logic [OccW-1:0]        occ_q;
  logic [QUEUE_DEPTH-1:0] valid_q;
  logic [TrackW-1:0]      head_q;
  logic [TrackW-1:0]      start_q;
  logic [DepthW-1:0]      depth_q;
  logic                   drain_q;
  logic                   need_serve_q;
  logic                   eos_q;
  logic [TrackW-1:0]      trk_q;
  logic                   cmp_en_q;
  logic [IdxW-1:0]        cmp_idx_q;
  logic [TrackW-1:0]      rd_data_q;
  logic                   best_found_q;
  logic [IdxW-1:0]        best_idx_q;
  logic [TrackW-1:0]      best_trk_q;
  logic [TrackW-1:0]      best_dist_q;
  logic                   free_found_q;
  logic [IdxW-1:0]        free_idx_q;
  logic                   out_valid_q;
  logic [TrackW-1:0]      out_trk_q;
  logic [TrackW-1:0]      out_dist_q;
  logic                   out_last_q;
  logic [TrackW-1:0]      mem_q [QUEUE_DEPTH];

  logic [OccW-1:0]   eff_depth;
  logic [TrackW-1:0] cmp_dist;
  logic [TrackW-1:0] in_trk;
  logic [TrackW-1:0] cfg_trk;
  logic              cfg_wr;
  logic              out_free;
  logic              scan_first;

  always_comb begin
    if (depth_q == '0) begin
      eff_depth = OccW'(1);
    end else if (32'(depth_q) > QUEUE_DEPTH) begin
      eff_depth = OccDepth;
    end else begin
      eff_depth = OccW'(depth_q);
    end
  end

  assign cmp_dist   = (rd_data_q >= head_q) ? rd_data_q - head_q : head_q - rd_data_q;
  assign in_trk     = (32'(s_axis_tdata) >= TRACK_COUNT) ? TrackMax : s_axis_tdata;
  assign cfg_trk    = (32'(pwdata[7:0]) >= TRACK_COUNT) ? TrackMax : pwdata[7:0];
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign out_free   = !out_valid_q || m_axis_tready;
  assign scan_first = (scan_idx_q == '0);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_dist_q, out_trk_q};
  assign m_axis_tlast  = out_last_q;
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == RegActiveDepth) ? {27'd0, depth_q} : {24'd0, start_q};

  // Queue storage, one write port for insert and one registered read port for the scan
  always_ff @(posedge clk_i) begin
    if (state_q == S_INSERT && free_found_q) begin
      mem_q[free_idx_q] <= trk_q;
    end
    rd_data_q <= mem_q[scan_idx_q];
    cmp_idx_q <= scan_idx_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      scan_idx_q   <= '0;
      occ_q        <= '0;
      valid_q      <= '0;
      head_q       <= '0;
      start_q      <= '0;
      depth_q      <= DepthReset;
      drain_q      <= 1'b0;
      need_serve_q <= 1'b0;
      eos_q        <= 1'b0;
      trk_q        <= '0;
      cmp_en_q     <= 1'b0;
      best_found_q <= 1'b0;
      best_idx_q   <= '0;
      best_trk_q   <= '0;
      best_dist_q  <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      out_valid_q  <= 1'b0;
      out_trk_q    <= '0;
      out_dist_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      cmp_en_q <= (state_q == S_SCAN) && valid_q[scan_idx_q];

      if (cfg_wr) begin
        if (paddr[2] == RegStartTrack) begin
          start_q <= pwdata[7:0];
          head_q  <= cfg_trk;
        end else begin
          depth_q <= pwdata[4:0];
        end
      end

      // shared nearest-track comparator, one slot per cycle
      if (cmp_en_q && (!best_found_q || cmp_dist < best_dist_q)) begin
        best_found_q <= 1'b1;
        best_idx_q   <= cmp_idx_q;
        best_trk_q   <= rd_data_q;
        best_dist_q  <= cmp_dist;
      end else if (state_q == S_SCAN && scan_first) begin
        best_found_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            trk_q        <= in_trk;
            eos_q        <= s_axis_tlast;
            need_serve_q <= (occ_q >= eff_depth);
            drain_q      <= 1'b0;
            scan_idx_q   <= '0;
            state_q      <= S_SCAN;
          end
        end
        S_SCAN: begin
          // lowest free slot
          if (!valid_q[scan_idx_q] && (scan_first || !free_found_q)) begin
            free_found_q <= 1'b1;
            free_idx_q   <= scan_idx_q;
          end else if (scan_first) begin
            free_found_q <= 1'b0;
          end
          if (scan_idx_q == LastIdx) begin
            state_q <= S_SCAN_END;
          end else begin
            scan_idx_q <= scan_idx_q + IdxW'(1);
          end
        end
        S_SCAN_END: begin
          state_q <= S_SERVE;
        end
        S_SERVE: begin
          if (!drain_q && (!need_serve_q || !best_found_q)) begin
            state_q <= S_INSERT;
          end else if (drain_q && !best_found_q) begin
            state_q <= S_IDLE;
          end else if (out_free) begin
            out_valid_q         <= 1'b1;
            out_trk_q           <= best_trk_q;
            out_dist_q          <= best_dist_q;
            out_last_q          <= drain_q && (occ_q == OccW'(1));
            head_q              <= best_trk_q;
            valid_q[best_idx_q] <= 1'b0;
            occ_q               <= occ_q - OccW'(1);
            scan_idx_q          <= '0;
            if (!drain_q) begin
              if (!free_found_q || best_idx_q < free_idx_q) begin
                free_found_q <= 1'b1;
                free_idx_q   <= best_idx_q;
              end
              state_q <= S_INSERT;
            end else if (occ_q == OccW'(1)) begin
              state_q <= S_IDLE;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_INSERT: begin
          if (free_found_q) begin
            valid_q[free_idx_q] <= 1'b1;
            occ_q               <= occ_q + OccW'(1);
          end
          scan_idx_q <= '0;
          if (eos_q) begin
            drain_q <= 1'b1;
            state_q <= S_SCAN;
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == OccW'($countones(valid_q)))
    else $error("occupancy count out of step with slot valid bits");

  a_drain_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SERVE && drain_q) |-> best_found_q)
    else $error("drain scan found no pending track");

  a_insert_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INSERT) |-> free_found_q)
    else $error("insert without a free slot");

endmodule

// File: tb/sv/sstf_sched_checker.sv
// Checker for the SSTF disk request scheduler: watches the request, service and APB
// channels, predicts each service transaction and compares it field by field.
// Depends on sstf_pkg.
module sstf_sched_checker import sstf_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDef,
  parameter int TRACK_COUNT = TrackCountDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic             req_ready_i,
  input  logic [7:0]       req_track_i,
  input  logic             req_eos_i,
  input  logic             svc_valid_i,
  input  logic             svc_ready_i,
  input  logic [15:0]      svc_data_i,
  input  logic             svc_last_i,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic             pready_i,
  input  logic [AddrW-1:0] paddr_i,
  input  logic [DataW-1:0] pwdata_i,
  output int               pending_o,
  output int               error_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [TrackW-1:0] track;
    logic [TrackW-1:0] distance;
    logic              last;
  } service_t;

  service_t          expected_services[$];
  logic [TrackW-1:0] slot_track[QUEUE_DEPTH];
  logic              slot_used[QUEUE_DEPTH];
  logic [TrackW-1:0] head_track;
  logic [DepthW-1:0] depth_reg;
  int                occupancy;
  int                errors;

  function automatic logic [TrackW-1:0] saturate_track(logic [TrackW-1:0] t);
    if (t >= TRACK_COUNT) return TrackW'(TRACK_COUNT - 1);
    return t;
  endfunction

  function automatic int seek_len(logic [TrackW-1:0] a, logic [TrackW-1:0] b);
    return (a >= b) ? int'(a) - int'(b) : int'(b) - int'(a);
  endfunction

  // nearest valid slot to the head, lowest slot wins ties; -1 when empty
  function automatic int nearest_pending();
    int best;
    int best_dist;
    int d;
    best = -1;
    best_dist = 0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (slot_used[i]) begin
        d = seek_len(slot_track[i], head_track);
        if (best < 0 || d < best_dist) begin
          best = i;
          best_dist = d;
        end
      end
    end
    return best;
  endfunction

  function automatic service_t take_slot(int s);
    service_t r;
    r.track    = slot_track[s];
    r.distance = TrackW'(seek_len(slot_track[s], head_track));
    r.last     = 1'b0;
    head_track   = slot_track[s];
    slot_used[s] = 1'b0;
    if (occupancy > 0) occupancy--;
    return r;
  endfunction

  task automatic predict_services(logic [TrackW-1:0] raw, logic eos);
    logic [TrackW-1:0] trk;
    service_t          r;
    int                s;
    int                eff;
    bit                placed;
    trk = saturate_track(raw);
    eff = int'(depth_reg);
    if (eff < 1) eff = 1;
    if (eff > QUEUE_DEPTH) eff = QUEUE_DEPTH;
    if (occupancy >= eff || occupancy >= QUEUE_DEPTH) begin
      s = nearest_pending();
      if (s >= 0) begin
        r = take_slot(s);
        expected_services.push_back(r);
      end
    end
    placed = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (!placed && !slot_used[i]) begin
        slot_track[i] = trk;
        slot_used[i]  = 1'b1;
        occupancy++;
        placed = 1'b1;
      end
    end
    if (eos) begin
      s = nearest_pending();
      while (s >= 0) begin
        r = take_slot(s);
        s = nearest_pending();
        r.last = (s < 0);
        expected_services.push_back(r);
      end
      occupancy = 0;
    end
  endtask

  task automatic note_mismatch(string what, service_t exp, service_t got);
    if (errors < 10) begin
      $display("%0t: %s: expected track %0d distance %0d last %0d, got track %0d distance %0d last %0d",
               $realtime, what, exp.track, exp.distance, exp.last,
               got.track, got.distance, got.last);
    end
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    service_t got;
    service_t exp;
    if (!rst_ni) begin
      expected_services.delete();
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        slot_used[i]  = 1'b0;
        slot_track[i] = '0;
      end
      head_track = '0;
      depth_reg  = DepthReset;
      occupancy  = 0;
      errors     = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == RegStartTrack) begin
          head_track = saturate_track(pwdata_i[TrackW-1:0]);
        end else begin
          depth_reg = pwdata_i[DepthW-1:0];
        end
      end
      if (svc_valid_i && svc_ready_i) begin
        got.track    = svc_data_i[7:0];
        got.distance = svc_data_i[15:8];
        got.last     = svc_last_i;
        if (expected_services.size() == 0) begin
          note_mismatch("unexpected service transaction", '0, got);
        end else begin
          exp = expected_services.pop_front();
          if (exp.track !== got.track || exp.distance !== got.distance ||
              exp.last !== got.last) begin
            note_mismatch("service mismatch", exp, got);
          end
        end
      end
      if (req_valid_i && req_ready_i) predict_services(req_track_i, req_eos_i);
    end
    pending_o     <= expected_services.size();
    error_count_o <= errors;
  end

endmodule

// File: tb/sv/tb_sstf_disk_request_scheduler_unit.sv
// Testbench top for the SSTF disk request scheduler: clock, reset, APB setup, request
// and service stream drivers, verdict. Prediction lives in sstf_sched_checker.
// Depends on sstf_pkg, sstf_sched_checker and sstf_disk_request_scheduler_unit.
module tb_sstf_disk_request_scheduler_unit;
  import sstf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QD             = QueueDepthDef;
  localparam int CycleLimit     = 1_000_000;
  localparam int SettleCycles   = 4 * (QD + 3);
  localparam int LongHoldCycles = 400;
  localparam int RequestTarget  = 420;

  localparam logic [AddrW-1:0] AddrStartTrack  = {RegStartTrack, 2'b00};
  localparam logic [AddrW-1:0] AddrActiveDepth = {RegActiveDepth, 2'b00};

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;
  logic             s_axis_tlast;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [15:0]      m_axis_tdata;
  logic             m_axis_tlast;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  int pending_results;
  int error_count;
  int requests_sent;
  int holds_requested;
  bit steady_flow;

  sstf_disk_request_scheduler_unit u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  sstf_sched_checker u_checker (
    .clk_i, .rst_ni,
    .req_valid_i   (s_axis_tvalid),
    .req_ready_i   (s_axis_tready),
    .req_track_i   (s_axis_tdata),
    .req_eos_i     (s_axis_tlast),
    .svc_valid_i   (m_axis_tvalid),
    .svc_ready_i   (m_axis_tready),
    .svc_data_i    (m_axis_tdata),
    .svc_last_i    (m_axis_tlast),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .pending_o     (pending_results),
    .error_count_o (error_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic apb_write(logic [AddrW-1:0] addr, logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic issue_request(logic [7:0] trk, logic eos);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= trk;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    requests_sent++;
  endtask

  // block idle: all services returned, plus time for a scan that yields nothing
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic [7:0] random_track();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(200, 255));
    return 8'($urandom_range(0, 199));
  endfunction

  function automatic logic [DataW-1:0] pick_start();
    logic [DataW-1:0] noise;
    logic [7:0]       v;
    noise = $urandom();
    case ($urandom_range(0, 5))
      0: v = 8'd0;
      1: v = 8'd199;
      2: v = 8'd255;
      default: v = 8'($urandom_range(0, 255));
    endcase
    return {noise[DataW-1:8], v};
  endfunction

  function automatic logic [DataW-1:0] pick_depth();
    logic [DataW-1:0] noise;
    logic [4:0]       v;
    noise = $urandom();
    case ($urandom_range(0, 6))
      0: v = 5'd0;
      1: v = 5'd1;
      2: v = 5'd16;
      3: v = 5'd31;
      default: v = 5'($urandom_range(0, 31));
    endcase
    return {noise[DataW-1:5], v};
  endfunction

  task automatic run_sequence(int len, bit with_eos);
    for (int i = 0; i < len; i++) begin
      issue_request(random_track(), with_eos && (i == len - 1));
    end
  endtask

  // service side: per-transaction stall, plus one long hold on request
  initial begin
    int stall;
    int holds_done;
    holds_done    = 0;
    m_axis_tready = 1'b0;
    forever begin
      if (holds_requested > holds_done) begin
        holds_done++;
        m_axis_tready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
      end
      stall = steady_flow ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int phase;
    int seqs;
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tlast    = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    requests_sent   = 0;
    holds_requested = 0;
    steady_flow     = 1'b0;
    phase           = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tie between 110 and 90 around head 100, saturated track, queue at active depth at end of stream
    apb_write(AddrStartTrack, 32'd100);
    apb_write(AddrActiveDepth, 32'd3);
    issue_request(8'd110, 1'b0);
    issue_request(8'd90, 1'b0);
    issue_request(8'd150, 1'b0);
    issue_request(8'd255, 1'b0);
    issue_request(8'd0, 1'b1);
    wait_idle();

    // depth 0 behaves as 1, head saturates from 255
    apb_write(AddrStartTrack, 32'd255);
    apb_write(AddrActiveDepth, 32'd0);
    issue_request(8'd0, 1'b0);
    issue_request(8'd128, 1'b0);
    issue_request(8'd7, 1'b1);
    wait_idle();

    // depth above the queue size: fill all slots, then end of stream gives the longest drain
    apb_write(AddrStartTrack, 32'd0);
    apb_write(AddrActiveDepth, 32'd31);
    for (int i = 0; i < QD; i++) issue_request(8'((i * 37) % 256), 1'b0);
    issue_request(8'd199, 1'b1);
    wait_idle();

    while (requests_sent < RequestTarget) begin
      phase++;
      apb_write(AddrStartTrack, pick_start());
      if ($urandom_range(0, 3) != 0) apb_write(AddrActiveDepth, pick_depth());
      steady_flow = ($urandom_range(0, 3) == 0);
      if (phase == 3) begin
        steady_flow = 1'b0;
        holds_requested++;
      end
      seqs = $urandom_range(1, 3);
      for (int k = 0; k < seqs; k++) begin
        run_sequence($urandom_range(1, 22), $urandom_range(0, 9) != 0);
        if (phase == 5 && k == 0) wait_idle();
      end
      wait_idle();
    end

    if (error_count == 0 && pending_results == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/sstf_pkg.sv
rtl/sstf_disk_request_scheduler_unit.sv
tb/sv/sstf_sched_checker.sv
tb/sv/tb_sstf_disk_request_scheduler_unit.sv
